@@ hw/rtl/humidity_sensor_temp_frame_checker_core_macros.svh @@
// Assertion macros for the port-level frame checker checks
`ifndef HUMIDITY_SENSOR_TEMP_FRAME_CHECKER_CORE_MACROS_SVH
`define HUMIDITY_SENSOR_TEMP_FRAME_CHECKER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define HSTFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// Check that cons holds in the cycle after ante
`define HSTFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

@@ hw/rtl/hstfc_pkg.sv @@
// Types, codes and helper functions of the temperature frame checker
`timescale 1ns / 1ps

package hstfc_pkg;

    // Bus event codes
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_NACK     = 2'd1,
        KIND_CMD_FAIL = 2'd2
    } kind_t;

    // Attempt outcome codes
    typedef enum logic [2:0] {
        OUT_OK       = 3'd0,
        OUT_CMD_FAIL = 3'd1,
        OUT_NO_DATA  = 3'd2,
        OUT_BAD_TYPE = 3'd3,
        OUT_BAD_CRC  = 3'd4
    } outcome_t;

    // Configuration register indexes
    localparam logic CFG_ATTEMPT_LIMIT = 1'b0;
    localparam logic CFG_POLL_LIMIT    = 1'b1;

    localparam logic [2:0]  ATTEMPT_LIMIT_RESET = 3'd3;
    localparam logic [2:0]  POLL_LIMIT_RESET    = 3'd4;
    localparam logic [7:0]  CRC_POLY            = 8'h31;
    localparam logic [7:0]  STATUS_MASK         = 8'hFC;
    localparam int unsigned TYPE_BIT            = 1;
    localparam logic [14:0] SPAN_CENTI          = 15'd17572;
    localparam logic [14:0] OFFSET_CENTI        = 15'd4685;

    typedef struct packed {
        logic [2:0] attempt_limit;
        logic [2:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        outcome_t           outcome;
        logic               final_res;
        logic [2:0]         attempt_number;
        logic [15:0]        raw_reading;
        logic signed [14:0] temperature_centi;
    } res_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/humidity_sensor_temp_frame_checker_core.sv @@
// Top level of the temperature frame checker with retry and conversion
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    kind, data_byte
//   out       source     out_valid / out_ready  outcome, final_res, attempt_number,
//                                               raw_reading, temperature_centi
//   cfg       sink       cfg_we                 cfg_index, cfg_data
//
// One request per cycle while in_ready is high; an ending attempt's result is queued.
// The CRC step, the 17572 x raw multiply and the offset subtract are combinational.
// A two-entry result queue keeps in_ready high until both entries wait on out_ready.
// Reset restores attempt_limit 3, poll_limit 4 and clears the frame and retry state.
`timescale 1ns / 1ps

module humidity_sensor_temp_frame_checker_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         outcome,
    output logic               final_res,
    output logic [2:0]         attempt_number,
    output logic [15:0]        raw_reading,
    output logic signed [14:0] temperature_centi,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [2:0]         cfg_data
);

    hstfc_pkg::cfg_t cfg_reg;
    hstfc_pkg::res_t slot_reg [2];
    hstfc_pkg::res_t step_res;
    logic [1:0]      count_reg;
    logic            step_valid;
    logic            accept;
    logic            push;
    logic            pop;
    logic            wr_slot;

    assign in_ready = (count_reg != 2'd2);
    assign accept   = in_valid && in_ready;
    assign pop      = (count_reg != 2'd0) && out_ready;
    assign push     = accept && step_valid;
    assign wr_slot  = (count_reg == 2'd2) || (count_reg == 2'd1 && !pop);

    hstfc_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_limit <= hstfc_pkg::ATTEMPT_LIMIT_RESET;
            cfg_reg.poll_limit    <= hstfc_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hstfc_pkg::CFG_ATTEMPT_LIMIT)
                cfg_reg.attempt_limit <= cfg_data;
            else
                cfg_reg.poll_limit <= cfg_data;
        end
    end

    // Track the result queue fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Shift out the head and store new results
    always_ff @(posedge clk)
    begin
        if (push && !wr_slot)
            slot_reg[0] <= step_res;
        else if (pop)
            slot_reg[0] <= slot_reg[1];
        if (push && wr_slot)
            slot_reg[1] <= step_res;
    end

    // Drive the head entry
    assign out_valid         = (count_reg != 2'd0);
    assign outcome           = slot_reg[0].outcome;
    assign final_res         = slot_reg[0].final_res;
    assign attempt_number    = slot_reg[0].attempt_number;
    assign raw_reading       = slot_reg[0].raw_reading;
    assign temperature_centi = slot_reg[0].temperature_centi;

endmodule

@@ hw/rtl/hstfc_frame.sv @@
// Frame assembly, CRC check, retry bookkeeping and temperature conversion
`timescale 1ns / 1ps

module hstfc_frame
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          kind,
    input  logic [7:0]          data_byte,
    input  hstfc_pkg::cfg_t     cfg,
    output logic                res_valid,
    output hstfc_pkg::res_t     res
);

    logic [1:0] byte_position_reg, byte_position_next;
    logic [7:0] high_byte_reg, high_byte_next;
    logic [7:0] low_byte_reg, low_byte_next;
    logic [7:0] running_crc_reg, running_crc_next;
    logic [2:0] nack_polls_reg, nack_polls_next;
    logic [2:0] attempts_done_reg, attempts_done_next;

    logic [3:0]  nack_inc;
    logic [2:0]  attempt_inc;
    logic [2:0]  limit;
    logic        fin;
    logic        end_attempt;
    hstfc_pkg::outcome_t code;
    logic [15:0] frame_raw;
    logic [30:0] product;
    logic [14:0] scaled;

    // Convert the held frame to centidegrees
    assign frame_raw = {high_byte_reg, low_byte_reg & hstfc_pkg::STATUS_MASK};
    assign product   = 31'(hstfc_pkg::SPAN_CENTI) * 31'(frame_raw);
    assign scaled    = product[30:16];

    assign nack_inc    = {1'b0, nack_polls_reg} + 4'd1;
    assign attempt_inc = attempts_done_reg + 3'd1;
    assign limit       = (cfg.attempt_limit == 3'd0) ? 3'd1 : cfg.attempt_limit;

    // Decode the event and pick an outcome
    always_comb
    begin
        end_attempt = 1'b0;
        code        = hstfc_pkg::OUT_OK;
        case (kind)
            hstfc_pkg::KIND_BYTE:
            begin
                if (byte_position_reg == 2'd2 || byte_position_reg == 2'd3)
                begin
                    end_attempt = 1'b1;
                    if (low_byte_reg[hstfc_pkg::TYPE_BIT])
                        code = hstfc_pkg::OUT_BAD_TYPE;
                    else if (running_crc_reg != data_byte)
                        code = hstfc_pkg::OUT_BAD_CRC;
                    else
                        code = hstfc_pkg::OUT_OK;
                end
            end
            hstfc_pkg::KIND_NACK:
            begin
                if (nack_inc > {1'b0, cfg.poll_limit})
                begin
                    end_attempt = 1'b1;
                    code        = hstfc_pkg::OUT_NO_DATA;
                end
            end
            hstfc_pkg::KIND_CMD_FAIL:
            begin
                end_attempt = 1'b1;
                code        = hstfc_pkg::OUT_CMD_FAIL;
            end
            default:
            begin
                end_attempt = 1'b0;
            end
        endcase
        fin = (code == hstfc_pkg::OUT_OK) || (attempt_inc >= limit) || (attempt_inc == 3'd0);
    end

    // Build the result of an ended attempt
    always_comb
    begin
        res_valid              = end_attempt;
        res.outcome            = code;
        res.final_res          = fin;
        res.attempt_number     = attempt_inc;
        res.raw_reading        = (code == hstfc_pkg::OUT_CMD_FAIL ||
                                  code == hstfc_pkg::OUT_NO_DATA) ? 16'd0 : frame_raw;
        res.temperature_centi  = (code == hstfc_pkg::OUT_OK) ?
                                 signed'(scaled - hstfc_pkg::OFFSET_CENTI) : 15'sd0;
    end

    // Advance the frame and retry state
    always_comb
    begin
        byte_position_next = byte_position_reg;
        high_byte_next     = high_byte_reg;
        low_byte_next      = low_byte_reg;
        running_crc_next   = running_crc_reg;
        nack_polls_next    = nack_polls_reg;
        attempts_done_next = attempts_done_reg;
        case (kind)
            hstfc_pkg::KIND_BYTE:
            begin
                if (byte_position_reg == 2'd0)
                begin
                    high_byte_next     = data_byte;
                    running_crc_next   = hstfc_pkg::crc8_byte(8'd0, data_byte);
                    byte_position_next = 2'd1;
                end
                else if (byte_position_reg == 2'd1)
                begin
                    low_byte_next      = data_byte;
                    running_crc_next   = hstfc_pkg::crc8_byte(running_crc_reg, data_byte);
                    byte_position_next = 2'd2;
                end
            end
            hstfc_pkg::KIND_NACK:
            begin
                byte_position_next = 2'd0;
                running_crc_next   = 8'd0;
                nack_polls_next    = nack_inc[2:0];
            end
            hstfc_pkg::KIND_CMD_FAIL:
            begin
                byte_position_next = 2'd0;
                running_crc_next   = 8'd0;
            end
            default:
            begin
                byte_position_next = byte_position_reg;
            end
        endcase
        if (end_attempt)
        begin
            byte_position_next = 2'd0;
            running_crc_next   = 8'd0;
            nack_polls_next    = 3'd0;
            attempts_done_next = fin ? 3'd0 : attempt_inc;
        end
    end

    // Hold state between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 2'd0;
            high_byte_reg     <= 8'd0;
            low_byte_reg      <= 8'd0;
            running_crc_reg   <= 8'd0;
            nack_polls_reg    <= 3'd0;
            attempts_done_reg <= 3'd0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            high_byte_reg     <= high_byte_next;
            low_byte_reg      <= low_byte_next;
            running_crc_reg   <= running_crc_next;
            nack_polls_reg    <= nack_polls_next;
            attempts_done_reg <= attempts_done_next;
        end
    end

endmodule

@@ hw/rtl/hstfc_checker.sv @@
// Port-level checks of the temperature frame checker, bound to the top level
`timescale 1ns / 1ps
`include "humidity_sensor_temp_frame_checker_core_macros.svh"

module hstfc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         kind,
    input logic [7:0]         data_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         outcome,
    input logic               final_res,
    input logic [2:0]         attempt_number,
    input logic [15:0]        raw_reading,
    input logic signed [14:0] temperature_centi,
    input logic               cfg_we,
    input logic               cfg_index,
    input logic [2:0]         cfg_data
);

    // A stalled result holds
    `HSTFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(attempt_number) && $stable(temperature_centi))

    // Input stalls only while a result is waiting
    `HSTFC_ASSERT_SAME(a_stall_has_result, !in_ready, out_valid)

    // A good attempt always ends the read
    `HSTFC_ASSERT_SAME(a_ok_final, out_valid && outcome == hstfc_pkg::OUT_OK, final_res)

    // Failed attempts carry no temperature and a nonzero attempt number
    `HSTFC_ASSERT_SAME(a_fail_no_temp, out_valid && outcome != hstfc_pkg::OUT_OK, temperature_centi == 15'sd0 && attempt_number != 3'd0)

endmodule

bind humidity_sensor_temp_frame_checker_core hstfc_checker u_hstfc_checker (.*);

@@ dv/hstfc_tb_pkg.sv @@
// Shared testbench constants and the CRC-8 helper used to build and judge frames
`timescale 1ns / 1ps

package hstfc_tb_pkg;

    // Event code that the block must ignore
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Fold one byte into a CRC-8, polynomial x^8+x^5+x^4+1, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        acc = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (acc[7])
                acc = {acc[6:0], 1'b0} ^ 8'h31;
            else
                acc = {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

@@ dv/hstfc_reading_checker.sv @@
// Predicts temperature read outcomes from the observed channels and compares them
`timescale 1ns / 1ps

module hstfc_reading_checker
    import hstfc_pkg::*;
    import hstfc_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         data_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         outcome,
    input  logic               final_res,
    input  logic [2:0]         attempt_number,
    input  logic [15:0]        raw_reading,
    input  logic signed [14:0] temperature_centi,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [2:0]         cfg_data,
    output int                 error_count,
    output int                 pending_count
);

    // Predictor copy of the configuration and the frame/retry state
    logic [2:0] attempt_cap;
    logic [2:0] poll_cap;
    logic [1:0] frame_pos;
    logic [7:0] frame_hi;
    logic [7:0] frame_lo;
    logic [7:0] frame_crc;
    logic [3:0] nack_seen;
    logic [2:0] attempts_taken;

    res_t outcome_q[$];

    // Close the current attempt and queue the outcome it yields
    task automatic close_attempt(input outcome_t code, input logic [15:0] raw);
        logic [2:0]  cap;
        logic        done;
        logic [31:0] scaled;
        res_t        r;
        cap = (attempt_cap == 3'd0) ? 3'd1 : attempt_cap;
        attempts_taken = attempts_taken + 3'd1;
        done = (code == OUT_OK) || (attempts_taken >= cap) || (attempts_taken == 3'd0);
        r.outcome = code;
        r.final_res = done;
        r.attempt_number = attempts_taken;
        r.raw_reading = (code == OUT_CMD_FAIL || code == OUT_NO_DATA) ? 16'd0 : raw;
        r.temperature_centi = '0;
        if (code == OUT_OK)
        begin
            scaled = 32'(SPAN_CENTI) * 32'(raw);
            r.temperature_centi = 15'(scaled[31:16]) - OFFSET_CENTI;
        end
        outcome_q.push_back(r);
        frame_pos = 2'd0;
        frame_crc = 8'd0;
        nack_seen = 4'd0;
        if (done)
            attempts_taken = 3'd0;
    endtask

    // Advance the predictor by one accepted bus event
    task automatic take_event(input logic [1:0] k, input logic [7:0] b);
        logic [15:0] raw;
        case (k)
            KIND_BYTE:
            begin
                if (frame_pos == 2'd0)
                begin
                    frame_hi = b;
                    frame_crc = crc8_update(8'd0, b);
                    frame_pos = 2'd1;
                end
                else if (frame_pos == 2'd1)
                begin
                    frame_lo = b;
                    frame_crc = crc8_update(frame_crc, b);
                    frame_pos = 2'd2;
                end
                else
                begin
                    // Type bit is judged before the CRC
                    raw = {frame_hi, frame_lo & STATUS_MASK};
                    if (frame_lo[TYPE_BIT])
                        close_attempt(OUT_BAD_TYPE, raw);
                    else if (frame_crc != b)
                        close_attempt(OUT_BAD_CRC, raw);
                    else
                        close_attempt(OUT_OK, raw);
                end
            end
            KIND_NACK:
            begin
                // Drop any partial frame, then count the poll
                frame_pos = 2'd0;
                frame_crc = 8'd0;
                nack_seen = nack_seen + 4'd1;
                if (nack_seen > {1'b0, poll_cap})
                    close_attempt(OUT_NO_DATA, 16'd0);
            end
            KIND_CMD_FAIL:
            begin
                frame_pos = 2'd0;
                frame_crc = 8'd0;
                close_attempt(OUT_CMD_FAIL, 16'd0);
            end
            default:
            begin
            end
        endcase
    endtask

    // Compare one delivered result against the oldest prediction
    task automatic check_result();
        res_t want;
        if (outcome_q.size() == 0)
        begin
            $error("result with no request pending: outcome %0d", outcome);
            error_count++;
            return;
        end
        want = outcome_q.pop_front();
        if (outcome !== want.outcome)
        begin
            $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
            error_count++;
        end
        if (final_res !== want.final_res)
        begin
            $error("final_res: expected %0d, actual %0d", want.final_res, final_res);
            error_count++;
        end
        if (attempt_number !== want.attempt_number)
        begin
            $error("attempt_number: expected %0d, actual %0d",
                   want.attempt_number, attempt_number);
            error_count++;
        end
        if (raw_reading !== want.raw_reading)
        begin
            $error("raw_reading: expected 0x%04h, actual 0x%04h",
                   want.raw_reading, raw_reading);
            error_count++;
        end
        if (temperature_centi !== want.temperature_centi)
        begin
            $error("temperature_centi: expected %0d, actual %0d",
                   $signed(want.temperature_centi), temperature_centi);
            error_count++;
        end
    endtask

    initial
    begin
        error_count = 0;
        pending_count = 0;
    end

    // Sample all channels on the rising edge; results first, then config, then requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_cap = ATTEMPT_LIMIT_RESET;
            poll_cap = POLL_LIMIT_RESET;
            frame_pos = 2'd0;
            frame_hi = 8'd0;
            frame_lo = 8'd0;
            frame_crc = 8'd0;
            nack_seen = 4'd0;
            attempts_taken = 3'd0;
            outcome_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == CFG_ATTEMPT_LIMIT)
                    attempt_cap = cfg_data;
                else
                    poll_cap = cfg_data;
            end
            if (in_valid && in_ready)
                take_event(kind, data_byte);
        end
        pending_count = outcome_q.size();
    end

endmodule

@@ dv/tb_humidity_sensor_temp_frame_checker_core.sv @@
// Stimulus and verdict for the temperature frame checker core
`timescale 1ns / 1ps

module tb_humidity_sensor_temp_frame_checker_core;
    import hstfc_pkg::*;
    import hstfc_tb_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } ready_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         kind = KIND_BYTE;
    logic [7:0]         data_byte = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         outcome;
    logic               final_res;
    logic [2:0]         attempt_number;
    logic [15:0]        raw_reading;
    logic signed [14:0] temperature_centi;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_ATTEMPT_LIMIT;
    logic [2:0]         cfg_data = 3'd0;

    int          error_count;
    int          pending_count;
    int          burst_left = 0;
    int          ready_seg_left = 0;
    ready_mode_e ready_mode = READY_ALWAYS;
    logic [2:0]  cur_polls = POLL_LIMIT_RESET;

    humidity_sensor_temp_frame_checker_core i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .outcome           (outcome),
        .final_res         (final_res),
        .attempt_number    (attempt_number),
        .raw_reading       (raw_reading),
        .temperature_centi (temperature_centi),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    hstfc_reading_checker i_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .outcome           (outcome),
        .final_res         (final_res),
        .attempt_number    (attempt_number),
        .raw_reading       (raw_reading),
        .temperature_centi (temperature_centi),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .error_count       (error_count),
        .pending_count     (pending_count)
    );

    always #1 clk = ~clk;

    // Stall the result side in segments of differing ready density
    always @(negedge clk)
    begin
        if (ready_seg_left == 0)
        begin
            ready_seg_left = $urandom_range(10, 200);
            ready_mode = ready_mode_e'($urandom_range(0, 2));
        end
        else
            ready_seg_left--;
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
            default:      out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Present one request in bursts with random gaps, hold until accepted
    task automatic send_event(input logic [1:0] k, input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] ck);
        send_event(KIND_BYTE, hi);
        send_event(KIND_BYTE, lo);
        send_event(KIND_BYTE, ck);
    endtask

    function automatic logic [7:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_update(crc8_update(8'd0, hi), lo);
    endfunction

    // Hold off the sender until every predicted result has been delivered
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limits(input logic [2:0] attempts, input logic [2:0] polls);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ATTEMPT_LIMIT;
        cfg_data <= attempts;
        @(negedge clk);
        cfg_index <= CFG_POLL_LIMIT;
        cfg_data <= polls;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_polls = polls;
    endtask

    // Well-formed polls and frames, plus broken frames, command failures, excess polls and noise
    task automatic run_random(input int count);
        int         sent;
        int         pick;
        int         polls;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [1:0] k;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            hi = 8'($urandom);
            lo = 8'($urandom);
            if (pick < 45)
            begin
                // Good read, optionally preceded by allowed nacks
                polls = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, cur_polls);
                repeat (polls) send_event(KIND_NACK, 8'($urandom));
                lo[TYPE_BIT] = 1'b0;
                send_frame(hi, lo, frame_crc(hi, lo));
                sent += polls + 3;
            end
            else if (pick < 55)
            begin
                lo[TYPE_BIT] = 1'b1;
                send_frame(hi, lo, ($urandom_range(0, 1) == 0) ? frame_crc(hi, lo) : 8'($urandom));
                sent += 3;
            end
            else if (pick < 65)
            begin
                lo[TYPE_BIT] = 1'b0;
                send_frame(hi, lo, frame_crc(hi, lo) ^ 8'($urandom_range(1, 255)));
                sent += 3;
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_event(KIND_BYTE, hi);
                    sent++;
                end
                send_event(KIND_CMD_FAIL, 8'($urandom));
                sent++;
            end
            else if (pick < 85)
            begin
                polls = cur_polls + 1 + $urandom_range(0, 1);
                repeat (polls) send_event(KIND_NACK, 8'($urandom));
                sent += polls;
            end
            else
            begin
                k = 2'($urandom_range(0, 3));
                send_event(k, 8'($urandom));
                if (k != KIND_RESERVED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        logic [2:0] att_set[4];
        logic [2:0] poll_set[4];
        att_set = '{3'd1, 3'd7, 3'd0, 3'd2};
        poll_set = '{3'd0, 3'd7, 3'd2, 3'd1};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes of the reading, each outcome and the retry count
        send_frame(8'h00, 8'h00, frame_crc(8'h00, 8'h00));
        send_frame(8'hFF, 8'hFC, frame_crc(8'hFF, 8'hFC));
        send_frame(8'hFF, 8'hFF, 8'h00);
        send_frame(8'h5A, 8'h10, frame_crc(8'h5A, 8'h10) ^ 8'h01);
        send_event(KIND_CMD_FAIL, 8'hFF);
        repeat (4) send_event(KIND_NACK, 8'h00);
        send_frame(8'h66, 8'h68, frame_crc(8'h66, 8'h68));
        // Nack inside a frame drops it and counts toward the poll limit
        send_event(KIND_BYTE, 8'hA5);
        repeat (5) send_event(KIND_NACK, 8'h55);
        // Reserved kind is ignored mid-frame; command failure drops the frame
        send_event(KIND_BYTE, 8'h3C);
        send_event(KIND_RESERVED, 8'hAA);
        send_event(KIND_CMD_FAIL, 8'h00);
        send_event(KIND_BYTE, 8'h81);
        send_event(KIND_RESERVED, 8'h7E);
        send_event(KIND_BYTE, 8'h40);
        send_event(KIND_BYTE, frame_crc(8'h81, 8'h40));
        settle();

        // Random phases over fixed extremes, then random settings
        for (int p = 0; p < 8; p++)
        begin
            if (p < 4)
                write_limits(att_set[p], poll_set[p]);
            else
                write_limits(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            run_random(190);
            settle();
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(1_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
